// ===== src/arrt_pkg.sv =====
// Shared types, constants and helpers for the acknowledgement retry tracking table.
`default_nettype none
package arrt_pkg;

    localparam int ARRT_ENTRIES   = 16;
    localparam int ARRT_KEY_BITS  = 64;
    localparam int ARRT_KEY_FIELD = 64;
    localparam int ARRT_TIME_W    = 32;
    localparam int ARRT_COUNT_W   = 8;
    localparam int ARRT_CMD_W     = 2;
    localparam int ARRT_S_DATA_W  = 104;
    localparam int ARRT_M_DATA_W  = 16;
    localparam int ARRT_CFG_IDX_W = 8;
    localparam int ARRT_CFG_DAT_W = 32;

    localparam logic [31:0] ARRT_TIMEOUT_RST = 32'd1000;
    localparam logic [7:0]  ARRT_MAX_RST     = 8'd3;

    localparam logic [ARRT_CMD_W-1:0] CMD_TRACK = 2'd0;
    localparam logic [ARRT_CMD_W-1:0] CMD_RETRY = 2'd1;
    localparam logic [ARRT_CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [ARRT_CFG_IDX_W-1:0] REG_RETRY_TIMEOUT = 8'd0;
    localparam logic [ARRT_CFG_IDX_W-1:0] REG_RETRY_LIMIT   = 8'd1;

    typedef struct packed {
        logic                    valid;
        logic [ARRT_CMD_W-1:0]   cmd;
        logic [ARRT_TIME_W-1:0]  now;
        logic                    hit;
        logic                    retry;
        logic                    free_found;
        logic [ARRT_COUNT_W-1:0] count;
    } arrt_tok_t;

    typedef struct packed {
        logic                   en;
        logic [ARRT_TIME_W-1:0] now;
    } arrt_alloc_t;

    function automatic logic [ARRT_COUNT_W-1:0] arrt_bump(input logic [ARRT_COUNT_W-1:0] c);
        arrt_bump = (c == '1) ? c : c + 1'b1;
    endfunction

endpackage
`default_nettype wire

// ===== src/arrt_cell.sv =====
// One table entry that checks and updates itself as the lookup item passes through.
`default_nettype none
module arrt_cell import arrt_pkg::*; #(
    parameter int KEY_BITS   = ARRT_KEY_BITS,
    parameter int IDX_W      = 4,
    parameter int CELL_INDEX = 0
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire arrt_tok_t               tok_in,
    input  wire logic [KEY_BITS-1:0]     key_in,
    input  wire logic [IDX_W-1:0]        free_idx_in,
    output arrt_tok_t                    tok_out,
    output logic [KEY_BITS-1:0]          key_out,
    output logic [IDX_W-1:0]             free_idx_out,
    input  wire logic [ARRT_TIME_W-1:0]  retry_timeout,
    input  wire logic [ARRT_COUNT_W-1:0] retry_limit,
    input  wire arrt_alloc_t             alloc,
    input  wire logic [IDX_W-1:0]        alloc_idx,
    input  wire logic [KEY_BITS-1:0]     alloc_key
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

    logic                    valid_reg, valid_next;
    logic [KEY_BITS-1:0]     ekey_reg, ekey_next;
    logic [ARRT_TIME_W-1:0]  etime_reg, etime_next;
    logic [ARRT_COUNT_W-1:0] eatt_reg, eatt_next;
    arrt_tok_t               tok_reg, tok_next;
    logic [KEY_BITS-1:0]     key_reg, key_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic                    hit;
    logic                    grant;
    logic [ARRT_TIME_W-1:0]  elapsed;

    always_comb begin
        valid_next = valid_reg;
        ekey_next  = ekey_reg;
        etime_next = etime_reg;
        eatt_next  = eatt_reg;
        tok_next   = tok_in;
        key_next   = key_in;
        idx_next   = free_idx_in;
        elapsed    = tok_in.now - etime_reg;
        grant      = (elapsed >= retry_timeout) && (eatt_reg <= retry_limit);
        hit        = tok_in.valid && !tok_in.hit && valid_reg && (ekey_reg == key_in);
        if (hit) begin
            case (tok_in.cmd)
                CMD_TRACK: begin
                    etime_next     = tok_in.now;
                    eatt_next      = arrt_bump(eatt_reg);
                    tok_next.hit   = 1'b1;
                    tok_next.count = arrt_bump(eatt_reg);
                end
                CMD_RETRY: begin
                    tok_next.hit   = 1'b1;
                    tok_next.retry = grant;
                    tok_next.count = grant ? arrt_bump(eatt_reg) : eatt_reg;
                    if (grant) begin
                        etime_next = tok_in.now;
                        eatt_next  = arrt_bump(eatt_reg);
                    end
                end
                CMD_CLEAR: begin
                    valid_next     = 1'b0;
                    tok_next.hit   = 1'b1;
                    tok_next.count = '0;
                end
                default: begin
                end
            endcase
        end
        if (tok_in.valid && !valid_reg && !tok_in.free_found) begin
            tok_next.free_found = 1'b1;
            idx_next            = MY_IDX;
        end
        if (alloc.en && (alloc_idx == MY_IDX)) begin
            valid_next = 1'b1;
            ekey_next  = alloc_key;
            etime_next = alloc.now;
            eatt_next  = ARRT_COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        ekey_reg  <= ekey_next;
        etime_reg <= etime_next;
        eatt_reg  <= eatt_next;
        key_reg   <= key_next;
        idx_reg   <= idx_next;
    end

    assign tok_out      = tok_reg;
    assign key_out      = key_reg;
    assign free_idx_out = idx_reg;

endmodule
`default_nettype wire

// ===== src/ack_retry_tracking_table.sv =====
// Top level of the acknowledgement retry tracking table built as a chain of entry cells.
//
// Items arrive on the s_ stream: command, message key and current millisecond time.
// Each accepted item produces exactly one result item on the m_ stream.
// The lookup item walks through the row of entry cells, one cell per cycle. A track
// that misses writes the new entry into the lowest free slot in the same cycle the
// result is loaded. One item is in the table at a time, so no new item is taken
// before the last one is through; s_tready rises again in the cycle after the
// result is loaded into the output register.
// The output register holds a finished result while the next item is accepted and
// scanned; when the receiver stalls, the block waits with the next result until the
// output register is free. Synchronous reset empties the table and restores the
// retry timeout to 1000 ms and the retry limit to 3. The configuration channel is
// always ready and should only be written while no item is in flight.
`default_nettype none
module ack_retry_tracking_table import arrt_pkg::*; #(
    parameter int TABLE_ENTRIES = ARRT_ENTRIES,
    parameter int KEY_BITS      = ARRT_KEY_BITS
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // command [1:0], message_key [65:2], time_now_ms [97:66], zero fill [103:98]
    input  wire logic [ARRT_S_DATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // key_found [0], retry_now [1], table_full_drop [2], attempt_count [10:3], zero fill
    output logic [ARRT_M_DATA_W-1:0]       m_tdata,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [ARRT_CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ARRT_CFG_DAT_W-1:0] cfg_data
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    logic [ARRT_TIME_W-1:0]  timeout_reg;
    logic [ARRT_COUNT_W-1:0] max_reg;
    arrt_tok_t               tok_chain   [TABLE_ENTRIES+1];
    logic [KEY_BITS-1:0]     key_chain   [TABLE_ENTRIES+1];
    logic [IDX_W-1:0]        idx_chain   [TABLE_ENTRIES+1];
    logic [TABLE_ENTRIES:0]  chain_valid;
    arrt_tok_t               inj_tok_reg, inj_tok_next;
    logic [KEY_BITS-1:0]     inj_key_reg;
    arrt_tok_t               fin_tok_reg;
    logic [KEY_BITS-1:0]     fin_key_reg;
    logic [IDX_W-1:0]        fin_idx_reg;
    logic                    m_tvalid_reg;
    logic [ARRT_M_DATA_W-1:0] m_data_reg, m_data_next;
    logic                    s_accept;
    logic                    out_free;
    logic                    load_out;
    logic                    miss_track;
    logic                    res_drop;
    logic [ARRT_COUNT_W-1:0] res_count;
    arrt_alloc_t             alloc;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign load_out  = (state_reg == ST_FINISH) && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= ARRT_TIMEOUT_RST;
            max_reg     <= ARRT_MAX_RST;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_RETRY_TIMEOUT) begin
                timeout_reg <= cfg_data;
            end
            if (cfg_index == REG_RETRY_LIMIT) begin
                max_reg <= cfg_data[ARRT_COUNT_W-1:0];
            end
        end
    end

    always_comb begin
        inj_tok_next            = '0;
        inj_tok_next.valid      = s_accept;
        inj_tok_next.cmd        = s_tdata[ARRT_CMD_W-1:0];
        inj_tok_next.now        = s_tdata[ARRT_CMD_W+ARRT_KEY_FIELD +: ARRT_TIME_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inj_tok_reg <= '0;
        end else begin
            inj_tok_reg <= inj_tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        inj_key_reg <= s_tdata[ARRT_CMD_W +: KEY_BITS];
    end

    assign tok_chain[0] = inj_tok_reg;
    assign key_chain[0] = inj_key_reg;
    assign idx_chain[0] = '0;

    assign miss_track = (fin_tok_reg.cmd == CMD_TRACK) && !fin_tok_reg.hit;
    assign alloc      = '{en: load_out && miss_track && fin_tok_reg.free_found,
                          now: fin_tok_reg.now};

    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
            arrt_cell #(
                .KEY_BITS   (KEY_BITS),
                .IDX_W      (IDX_W),
                .CELL_INDEX (g)
            ) u_cell (
                .aclk          (aclk),
                .aresetn       (aresetn),
                .tok_in        (tok_chain[g]),
                .key_in        (key_chain[g]),
                .free_idx_in   (idx_chain[g]),
                .tok_out       (tok_chain[g+1]),
                .key_out       (key_chain[g+1]),
                .free_idx_out  (idx_chain[g+1]),
                .retry_timeout (timeout_reg),
                .retry_limit   (max_reg),
                .alloc         (alloc),
                .alloc_idx     (fin_idx_reg),
                .alloc_key     (fin_key_reg)
            );
        end
        for (g = 0; g <= TABLE_ENTRIES; g++) begin : g_vld
            assign chain_valid[g] = tok_chain[g].valid;
        end
    endgenerate

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (tok_chain[TABLE_ENTRIES].valid) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_SCAN) begin
            fin_tok_reg <= tok_chain[TABLE_ENTRIES];
            fin_key_reg <= key_chain[TABLE_ENTRIES];
            fin_idx_reg <= idx_chain[TABLE_ENTRIES];
        end
    end

    assign res_drop  = miss_track && !fin_tok_reg.free_found;
    assign res_count = miss_track ? ARRT_COUNT_W'(fin_tok_reg.free_found) : fin_tok_reg.count;

    always_comb begin
        m_data_next                       = '0;
        m_data_next[0]                    = fin_tok_reg.hit;
        m_data_next[1]                    = fin_tok_reg.retry;
        m_data_next[2]                    = res_drop;
        m_data_next[3 +: ARRT_COUNT_W]    = res_count;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(chain_valid))
        else $error("More than one lookup item in the cell chain.");

    a_token_only_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (chain_valid != '0) |-> (state_reg == ST_SCAN))
        else $error("Lookup item in the chain outside the scan state.");

    a_load_gives_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> m_tvalid)
        else $error("Loaded result did not show on the output.");

    a_retry_needs_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1]) |-> m_tdata[0])
        else $error("Retry granted without a matching entry.");

    a_drop_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[2]) |-> (!m_tdata[0] && (m_tdata[10:3] == '0)))
        else $error("Dropped item reports a match or a count.");

endmodule
`default_nettype wire
